### src/erb_pkg.sv
// Shared types and constants for the epoch reclamation engine.
// Used by erb_seq, erb_pend_mem and the top level; depends on nothing.
package erb_pkg;

  localparam int unsigned EpochW = 64;
  localparam int unsigned HandleW = 64;
  localparam int unsigned TagW = 8;
  localparam int unsigned ThrW = 6;
  localparam logic [ThrW-1:0] ThrReset = 6'd16;
  localparam logic [EpochW-1:0] EpochMax = {EpochW{1'b1}};

  typedef enum logic [2:0] {
    OP_REGISTER = 3'd0,
    OP_TICK     = 3'd1,
    OP_RETIRE   = 3'd2,
    OP_COLLECT  = 3'd3,
    OP_DRAIN    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_GRANT = 2'd0,
    KIND_FULL  = 2'd1,
    KIND_FREE  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_FLUSH,
    ST_PACK_RD,
    ST_PACK_CHK
  } state_e;

  typedef struct packed {
    logic [HandleW-1:0] handle;
    logic [TagW-1:0]    tag;
    logic [EpochW-1:0]  epoch;
  } pend_entry_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         slot;
    logic [HandleW-1:0] handle;
    logic [TagW-1:0]    tag;
    logic               last;
  } result_t;

endpackage

### src/erb_slot_mem.sv
// Per-slot table: quiescent epoch and retire stack count, registered read.
// Valid bits make unwritten entries read as zero. Depends on nothing.
module erb_slot_mem #(
  parameter int unsigned THREADS = 16,
  parameter int unsigned SW = 4,
  parameter int unsigned CW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          re_i,
  input  logic [SW-1:0] raddr_i,
  output logic [63:0]   rd_qe_o,
  output logic [CW-1:0] rd_cnt_o,
  input  logic [SW-1:0] waddr_i,
  input  logic          qe_we_i,
  input  logic [63:0]   qe_wdata_i,
  input  logic          cnt_we_i,
  input  logic [CW-1:0] cnt_wdata_i
);

  logic [63:0]        qe_mem [THREADS];
  logic [CW-1:0]      cnt_mem [THREADS];
  logic [THREADS-1:0] qv_q;
  logic [THREADS-1:0] cv_q;
  logic [63:0]        rd_qe_q;
  logic [CW-1:0]      rd_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qv_q <= '0;
      cv_q <= '0;
    end else begin
      if (qe_we_i) qv_q[waddr_i] <= 1'b1;
      if (cnt_we_i) cv_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (qe_we_i) qe_mem[waddr_i] <= qe_wdata_i;
    if (cnt_we_i) cnt_mem[waddr_i] <= cnt_wdata_i;
    if (re_i) begin
      rd_qe_q  <= qv_q[raddr_i] ? qe_mem[raddr_i] : '0;
      rd_cnt_q <= cv_q[raddr_i] ? cnt_mem[raddr_i] : '0;
    end
  end

  assign rd_qe_o  = rd_qe_q;
  assign rd_cnt_o = rd_cnt_q;

endmodule

### src/erb_pend_mem.sv
// Retire stack storage for all slots, one write and one registered read port.
// Depends on erb_pkg for the entry type.
module erb_pend_mem #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned PW = 9
) (
  input  logic                 clk_i,
  input  logic                 re_i,
  input  logic [PW-1:0]        raddr_i,
  output erb_pkg::pend_entry_t rdata_o,
  input  logic                 we_i,
  input  logic [PW-1:0]        waddr_i,
  input  erb_pkg::pend_entry_t wdata_i
);

  erb_pkg::pend_entry_t mem [DEPTH];
  erb_pkg::pend_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/erb_seq.sv
// Operation sequencer: global epoch, slot count and the read-modify-write
// walks over the slot table and retire stacks. Depends on erb_pkg.
module erb_seq #(
  parameter int unsigned THREADS = 16,
  parameter int unsigned STACK_DEPTH = 32,
  parameter int unsigned SW = 4,
  parameter int unsigned CW = 6,
  parameter int unsigned PW = 9
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  in_op_i,
  input  logic [4:0]                  in_slot_i,
  input  logic [erb_pkg::HandleW-1:0] in_handle_i,
  input  logic [erb_pkg::TagW-1:0]    in_tag_i,
  input  logic [erb_pkg::ThrW-1:0]    thr_i,
  output logic                        slot_re_o,
  output logic [SW-1:0]               slot_raddr_o,
  input  logic [63:0]                 slot_qe_i,
  input  logic [CW-1:0]               slot_cnt_i,
  output logic [SW-1:0]               slot_waddr_o,
  output logic                        qe_we_o,
  output logic [63:0]                 qe_wdata_o,
  output logic                        cnt_we_o,
  output logic [CW-1:0]               cnt_wdata_o,
  output logic                        pend_re_o,
  output logic [PW-1:0]               pend_raddr_o,
  input  erb_pkg::pend_entry_t        pend_rdata_i,
  output logic                        pend_we_o,
  output logic [PW-1:0]               pend_waddr_o,
  output erb_pkg::pend_entry_t        pend_wdata_o,
  input  logic                        can_push_i,
  output logic                        push_o,
  output erb_pkg::result_t            res_o
);

  localparam int unsigned NW = $clog2(THREADS + 1);
  localparam int unsigned CMPW = (CW > erb_pkg::ThrW) ? CW : erb_pkg::ThrW;

  erb_pkg::state_e  state_q, state_d;
  logic [2:0]       op_q, op_d;
  logic [SW-1:0]    s_q, s_d;
  logic             vld_q, vld_d;
  logic [63:0]      h_q, h_d;
  logic [7:0]       tag_q, tag_d;
  logic [63:0]      ge_q, ge_d;
  logic [NW-1:0]    sc_q, sc_d;
  logic [NW-1:0]    scan_q, scan_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    w_q, w_d;
  logic [63:0]      mn_q, mn_d;
  erb_pkg::result_t held_q, held_d;
  logic             held_v_q, held_v_d;
  logic             pack_q, pack_d;
  logic             drain_q, drain_d;
  logic [PW-1:0]    base;
  logic             in_vld;
  erb_pkg::result_t free_res;

  assign base = PW'(s_q) * PW'(STACK_DEPTH);
  assign in_vld = !in_slot_i[4] && (7'(in_slot_i[3:0]) < 7'(THREADS));

  always_comb begin
    free_res        = '0;
    free_res.kind   = erb_pkg::KIND_FREE;
    free_res.handle = pend_rdata_i.handle;
    free_res.tag    = pend_rdata_i.tag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= erb_pkg::ST_IDLE;
      ge_q     <= 64'd1;
      sc_q     <= '0;
      held_v_q <= 1'b0;
      pack_q   <= 1'b0;
      drain_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      ge_q     <= ge_d;
      sc_q     <= sc_d;
      held_v_q <= held_v_d;
      pack_q   <= pack_d;
      drain_q  <= drain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    s_q    <= s_d;
    vld_q  <= vld_d;
    h_q    <= h_d;
    tag_q  <= tag_d;
    scan_q <= scan_d;
    cnt_q  <= cnt_d;
    idx_q  <= idx_d;
    w_q    <= w_d;
    mn_q   <= mn_d;
    held_q <= held_d;
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    s_d          = s_q;
    vld_d        = vld_q;
    h_d          = h_q;
    tag_d        = tag_q;
    ge_d         = ge_q;
    sc_d         = sc_q;
    scan_d       = scan_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    w_d          = w_q;
    mn_d         = mn_q;
    held_d       = held_q;
    held_v_d     = held_v_q;
    pack_d       = pack_q;
    drain_d      = drain_q;
    in_ready_o   = 1'b0;
    slot_re_o    = 1'b0;
    slot_raddr_o = SW'(in_slot_i[3:0]);
    slot_waddr_o = s_q;
    qe_we_o      = 1'b0;
    qe_wdata_o   = ge_q;
    cnt_we_o     = 1'b0;
    cnt_wdata_o  = w_q;
    pend_re_o    = 1'b0;
    pend_raddr_o = base + PW'(idx_q);
    pend_we_o    = 1'b0;
    pend_waddr_o = base + PW'(w_q);
    pend_wdata_o = pend_rdata_i;
    push_o       = 1'b0;
    res_o        = held_q;

    unique case (state_q)
      erb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        slot_re_o  = 1'b1;
        if (in_valid_i) begin
          op_d    = in_op_i;
          s_d     = SW'(in_slot_i[3:0]);
          vld_d   = in_vld;
          h_d     = in_handle_i;
          tag_d   = in_tag_i;
          state_d = erb_pkg::ST_DECIDE;
        end
      end

      erb_pkg::ST_DECIDE: begin
        cnt_d    = slot_cnt_i;
        held_d   = '0;
        held_v_d = 1'b0;
        pack_d   = 1'b0;
        drain_d  = 1'b0;
        scan_d   = '0;
        mn_d     = erb_pkg::EpochMax;
        state_d  = erb_pkg::ST_IDLE;
        unique case (op_q)
          erb_pkg::OP_REGISTER: begin
            held_v_d = 1'b1;
            state_d  = erb_pkg::ST_FLUSH;
            if (sc_q >= NW'(THREADS)) begin
              held_d.kind = erb_pkg::KIND_FULL;
            end else begin
              slot_waddr_o = SW'(sc_q);
              qe_we_o      = 1'b1;
              cnt_we_o     = 1'b1;
              cnt_wdata_o  = '0;
              sc_d         = sc_q + NW'(1);
              held_d.kind  = erb_pkg::KIND_GRANT;
              held_d.slot  = 4'(sc_q);
            end
          end
          erb_pkg::OP_TICK: begin
            if (vld_q) begin
              qe_we_o = 1'b1;
              if (CMPW'(slot_cnt_i) >= CMPW'(thr_i)) state_d = erb_pkg::ST_SCAN_RD;
            end
          end
          erb_pkg::OP_RETIRE: begin
            if (h_q != '0) begin
              if (!vld_q) begin
                held_d.kind   = erb_pkg::KIND_FREE;
                held_d.handle = h_q;
                held_d.tag    = tag_q;
                held_v_d      = 1'b1;
                state_d       = erb_pkg::ST_FLUSH;
              end else begin
                ge_d = ge_q + 64'd1;
                if (slot_cnt_i >= CW'(STACK_DEPTH)) begin
                  held_d.kind   = erb_pkg::KIND_FREE;
                  held_d.handle = h_q;
                  held_d.tag    = tag_q;
                  held_v_d      = 1'b1;
                  state_d       = erb_pkg::ST_FLUSH;
                end else begin
                  pend_we_o           = 1'b1;
                  pend_waddr_o        = base + PW'(slot_cnt_i);
                  pend_wdata_o.handle = h_q;
                  pend_wdata_o.tag    = tag_q;
                  pend_wdata_o.epoch  = ge_q;
                  cnt_we_o            = 1'b1;
                  cnt_wdata_o         = slot_cnt_i + CW'(1);
                end
              end
            end
          end
          erb_pkg::OP_COLLECT: begin
            if (vld_q) state_d = erb_pkg::ST_SCAN_RD;
          end
          erb_pkg::OP_DRAIN: begin
            if (vld_q) begin
              cnt_we_o    = 1'b1;
              cnt_wdata_o = '0;
              drain_d     = 1'b1;
              idx_d       = slot_cnt_i;
              state_d     = erb_pkg::ST_WALK_RD;
            end
          end
          default: state_d = erb_pkg::ST_IDLE;
        endcase
      end

      // Minimum nonzero quiescent epoch over the registered slots.
      erb_pkg::ST_SCAN_RD: begin
        if (scan_q == sc_q) begin
          if (mn_q == erb_pkg::EpochMax) begin
            state_d = erb_pkg::ST_IDLE;
          end else begin
            idx_d   = cnt_q;
            state_d = erb_pkg::ST_WALK_RD;
          end
        end else begin
          slot_re_o    = 1'b1;
          slot_raddr_o = SW'(scan_q);
          scan_d       = scan_q + NW'(1);
          state_d      = erb_pkg::ST_SCAN_CHK;
        end
      end

      erb_pkg::ST_SCAN_CHK: begin
        if (slot_qe_i != '0 && slot_qe_i < mn_q) mn_d = slot_qe_i;
        state_d = erb_pkg::ST_SCAN_RD;
      end

      // Newest first; one found entry is held back so the final one carries last.
      erb_pkg::ST_WALK_RD: begin
        if (idx_q == '0) begin
          pack_d  = !drain_q;
          state_d = erb_pkg::ST_FLUSH;
        end else begin
          pend_re_o    = 1'b1;
          pend_raddr_o = base + PW'(idx_q - CW'(1));
          idx_d        = idx_q - CW'(1);
          state_d      = erb_pkg::ST_WALK_CHK;
        end
      end

      erb_pkg::ST_WALK_CHK: begin
        if (drain_q || pend_rdata_i.epoch < mn_q) begin
          if (!held_v_q || can_push_i) begin
            push_o   = held_v_q;
            held_d   = free_res;
            held_v_d = 1'b1;
            state_d  = erb_pkg::ST_WALK_RD;
          end
        end else begin
          state_d = erb_pkg::ST_WALK_RD;
        end
      end

      erb_pkg::ST_FLUSH: begin
        res_o.last = 1'b1;
        if (!held_v_q || can_push_i) begin
          push_o   = held_v_q;
          held_v_d = 1'b0;
          idx_d    = '0;
          w_d      = '0;
          state_d  = pack_q ? erb_pkg::ST_PACK_RD : erb_pkg::ST_IDLE;
        end
      end

      // Survivors move down to the bottom of the stack in their old order.
      erb_pkg::ST_PACK_RD: begin
        if (idx_q == cnt_q) begin
          cnt_we_o = 1'b1;
          state_d  = erb_pkg::ST_IDLE;
        end else begin
          pend_re_o = 1'b1;
          idx_d     = idx_q + CW'(1);
          state_d   = erb_pkg::ST_PACK_CHK;
        end
      end

      erb_pkg::ST_PACK_CHK: begin
        if (pend_rdata_i.epoch >= mn_q) begin
          pend_we_o = 1'b1;
          w_d       = w_q + CW'(1);
        end
        state_d = erb_pkg::ST_PACK_RD;
      end

      default: state_d = erb_pkg::ST_IDLE;
    endcase
  end

endmodule

### src/epoch_reclamation_engine.sv
// Top level of the epoch reclamation engine: stream ports, threshold register
// and output register. Depends on erb_pkg, erb_seq, erb_slot_mem, erb_pend_mem.
//
// Usage: requests enter on the s_axis channel (tuser = operation, tdata =
// caller slot, handle and release tag). Results leave on m_axis, tuser giving
// the kind, tlast marking the final result caused by a request. A request that
// causes no result (tick below threshold, retire into the stack, null handle,
// unknown operation) produces nothing on m_axis.
// The cfg channel writes the collection threshold and is always ready. The
// user must write it only while the engine is idle; the block does not enforce
// this. Timing: one request is processed at a time. A register or retire
// result is decided in the state after acceptance and is then pushed into the
// output register from the flush state; the next request is accepted only
// back in idle. A collection reads the slot table once per registered slot,
// then walks the caller's retire stack newest first and compacts it; drain
// walks the stack without compacting it. Each memory has a single read port.
// Reset: global epoch 1, no slots registered, every slot table entry reads as
// zero; no clearing pass is needed. Retire stacks are empty after reset, as their counts read as zero.
// Stall: a result waits in the output register; the walk pauses while that
// register is full and the receiver holds tready low, and nothing is lost.
module epoch_reclamation_engine #(
  parameter int unsigned THREADS = 16,
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] thread_slot, [68:5] handle, [76:69] freer_tag, [79:77] zero
  input  logic [79:0] s_axis_tdata,
  // [2:0] operation
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] granted_slot, [67:4] freed_handle, [75:68] freed_tag, [79:76] zero
  output logic [79:0] m_axis_tdata,
  // [1:0] kind
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_data_i
);

  localparam int unsigned SW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned PDEPTH = THREADS * STACK_DEPTH;
  localparam int unsigned PW = $clog2(PDEPTH);

  logic [erb_pkg::ThrW-1:0] thr_q;
  logic                     out_v_q;
  erb_pkg::result_t         out_q;
  logic                     can_push;
  logic                     push;
  erb_pkg::result_t         res;

  logic                 slot_re, qe_we, cnt_we, pend_re, pend_we;
  logic [SW-1:0]        slot_raddr, slot_waddr;
  logic [63:0]          slot_qe, qe_wdata;
  logic [CW-1:0]        slot_cnt, cnt_wdata;
  logic [PW-1:0]        pend_raddr, pend_waddr;
  erb_pkg::pend_entry_t pend_rdata, pend_wdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= erb_pkg::ThrReset;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // The output register frees up in the same cycle the receiver takes it.
  assign can_push = !out_v_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (can_push) begin
      out_v_q <= push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_push && push) out_q <= res;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {4'd0, out_q.tag, out_q.handle, out_q.slot};

  erb_seq #(
    .THREADS(THREADS), .STACK_DEPTH(STACK_DEPTH), .SW(SW), .CW(CW), .PW(PW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_op_i      (s_axis_tuser),
    .in_slot_i    (s_axis_tdata[4:0]),
    .in_handle_i  (s_axis_tdata[68:5]),
    .in_tag_i     (s_axis_tdata[76:69]),
    .thr_i        (thr_q),
    .slot_re_o    (slot_re),
    .slot_raddr_o (slot_raddr),
    .slot_qe_i    (slot_qe),
    .slot_cnt_i   (slot_cnt),
    .slot_waddr_o (slot_waddr),
    .qe_we_o      (qe_we),
    .qe_wdata_o   (qe_wdata),
    .cnt_we_o     (cnt_we),
    .cnt_wdata_o  (cnt_wdata),
    .pend_re_o    (pend_re),
    .pend_raddr_o (pend_raddr),
    .pend_rdata_i (pend_rdata),
    .pend_we_o    (pend_we),
    .pend_waddr_o (pend_waddr),
    .pend_wdata_o (pend_wdata),
    .can_push_i   (can_push),
    .push_o       (push),
    .res_o        (res)
  );

  erb_slot_mem #(.THREADS(THREADS), .SW(SW), .CW(CW)) u_slot_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .re_i        (slot_re),
    .raddr_i     (slot_raddr),
    .rd_qe_o     (slot_qe),
    .rd_cnt_o    (slot_cnt),
    .waddr_i     (slot_waddr),
    .qe_we_i     (qe_we),
    .qe_wdata_i  (qe_wdata),
    .cnt_we_i    (cnt_we),
    .cnt_wdata_i (cnt_wdata)
  );

  erb_pend_mem #(.DEPTH(PDEPTH), .PW(PW)) u_pend_mem (
    .clk_i   (clk_i),
    .re_i    (pend_re),
    .raddr_i (pend_raddr),
    .rdata_o (pend_rdata),
    .we_i    (pend_we),
    .waddr_i (pend_waddr),
    .wdata_i (pend_wdata)
  );

endmodule
